// File: sv/rpvr_pkg.sv
// Shared types and constants of the ramped PI voltage regulator.
// No dependencies; imported by the core, the gain unit, the checker and the testbench.
`default_nettype none

package rpvr_pkg;

    localparam int OUT_MAX      = 65536000;
    localparam int SYNC_START   = 200;
    localparam int SYNC_PERIOD  = 70;
    localparam int SYNC_TOGGLES = 5;

    localparam int IN_DATA_W  = 40;
    localparam int OUT_DATA_W = 72;
    localparam int CFG_W      = 31;
    localparam int CFG_IDX_W  = 3;
    localparam int GM_MAG_W   = 38;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SETPOINT,
        CFG_RAMP_STEP,
        CFG_PULSE_POINTS,
        CFG_PROP_GAIN,
        CFG_INTEGRAL_GAIN,
        CFG_ALLOWED_ERROR,
        CFG_FAULT_LIMIT,
        CFG_INTEGRAL_LIMIT
    } t_cfg_idx;

    // stage advance enables for the gain unit
    typedef struct packed {
        logic en1;
        logic en2;
        logic en3;
    } t_gm_ctl;

endpackage

`default_nettype wire

// File: sv/ramped_pi_voltage_regulator_core.sv
// Ramped PI voltage regulator core: eight-stage pipeline, one drive result per sample.
// Depends on rpvr_pkg and rpvr_gain_mul.
//
// Usage:
//   Samples enter on the s channel (tdata: measured voltage, fault mute;
//   tuser: action, 1 = start pulse). Each transfer yields exactly one result
//   on the m channel (tdata: drive, sync level, error; tuser: fault code;
//   tlast: pulse finished).
//   Registers are written through i_cfg_we / i_cfg_idx / i_cfg_data while
//   the pipeline is empty; a write takes effect on the next clock edge.
//   Throughput is one sample per cycle while the m channel accepts results;
//   the integral and follow-error loops each close within a single stage,
//   and the gain products take three stages in rpvr_gain_mul.
//   Each stage advances when it is empty or the stage after it advances, so
//   while the receiver stalls, samples are still taken until all stages
//   hold a pending item; then o_s_tready drops and all held data stays.
//   Reset (synchronous, active low) empties the pipeline and zeroes the
//   regulator state, sync counters and the configuration registers.
`default_nettype none

module ramped_pi_voltage_regulator_core (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    // tdata: [31:0] measured_voltage, [32] fault_mute, [39:33] zero
    input  wire logic [rpvr_pkg::IN_DATA_W-1:0]    i_s_tdata,
    // tuser: [0] action
    input  wire logic [0:0]                        i_s_tuser,
    input  wire logic                              i_s_tvalid,
    output logic                                   o_s_tready,
    // tdata: [31:0] drive_voltage, [32] sync_level, [64:33] error_value, [71:65] zero
    output logic [rpvr_pkg::OUT_DATA_W-1:0]        o_m_tdata,
    // tuser: [0] fault_code
    output logic [0:0]                             o_m_tuser,
    output logic                                   o_m_tlast,
    output logic                                   o_m_tvalid,
    input  wire logic                              i_m_tready,
    input  wire logic                              i_cfg_we,
    input  wire logic [rpvr_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  wire logic [rpvr_pkg::CFG_W-1:0]        i_cfg_data
);
    import rpvr_pkg::*;

    localparam logic signed [40:0] DRV_MAX = 41'(OUT_MAX);
    localparam logic signed [40:0] DRV_MIN = -41'sd2147483648;

    typedef struct packed {
        logic signed [31:0] target;
        logic signed [31:0] err;
        logic               fin;
        logic               fault;
        logic               sync;
        logic               start;
    } t_meta;

    function automatic logic signed [31:0] sat33(input logic signed [32:0] v);
        if (v[32] != v[31]) begin
            return v[32] ? 32'sh8000_0000 : 32'sh7fff_ffff;
        end
        return v[31:0];
    endfunction

    // configuration
    logic [30:0] r_setpoint, r_ramp_step, r_allowed, r_integral_limit;
    logic [15:0] r_pulse_points, r_prop_gain, r_integral_gain, r_fault_limit;

    // regulator state
    logic signed [31:0] r_target, r_integral;
    logic [15:0] r_pc, r_follow;
    logic [6:0]  r_toggle;
    logic [2:0]  r_sync_cnt;
    logic        r_sync_line;

    logic [8:1] r_vld;
    logic [8:1] en;

    // stage payloads
    logic               r_p1_start, r_p1_mute, r_p1_ramp;
    logic signed [31:0] r_p1_meas, r_p1_target;
    logic               r_p2_start, r_p2_mute, r_p2_ramp;
    logic signed [31:0] r_p2_raw, r_p2_target;
    t_meta              r_meta [3:7];
    logic signed [31:0] r_p7_qi;
    logic [GM_MAG_W-1:0] r_p7_qp_mag;
    logic               r_p7_qp_neg;
    logic signed [31:0] r_out_drive, r_out_err;
    logic               r_out_fin, r_out_fault, r_out_sync;

    // flow control
    always_comb begin
        en[8] = !r_vld[8] || i_m_tready;
        for (int k = 7; k >= 1; k--) begin
            en[k] = !r_vld[k] || en[k+1];
        end
    end

    assign o_s_tready = en[1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (en[1]) begin
                r_vld[1] <= i_s_tvalid;
            end
            for (int k = 2; k <= 8; k++) begin
                if (en[k]) begin
                    r_vld[k] <= r_vld[k-1];
                end
            end
        end
    end

    // configuration port
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_setpoint       <= '0;
            r_ramp_step      <= '0;
            r_pulse_points   <= '0;
            r_prop_gain      <= '0;
            r_integral_gain  <= '0;
            r_allowed        <= '0;
            r_fault_limit    <= '0;
            r_integral_limit <= '0;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_idx))
                CFG_SETPOINT:       r_setpoint       <= i_cfg_data;
                CFG_RAMP_STEP:      r_ramp_step      <= i_cfg_data;
                CFG_PULSE_POINTS:   r_pulse_points   <= i_cfg_data[15:0];
                CFG_PROP_GAIN:      r_prop_gain      <= i_cfg_data[15:0];
                CFG_INTEGRAL_GAIN:  r_integral_gain  <= i_cfg_data[15:0];
                CFG_ALLOWED_ERROR:  r_allowed        <= i_cfg_data;
                CFG_FAULT_LIMIT:    r_fault_limit    <= i_cfg_data[15:0];
                CFG_INTEGRAL_LIMIT: r_integral_limit <= i_cfg_data;
            endcase
        end
    end

    // stage 1: setpoint ramp
    logic               in_start, in_acc, ramping;
    logic signed [32:0] ramp_sum;
    logic signed [31:0] n_target;

    assign in_start = i_s_tuser[0];
    assign in_acc   = i_s_tvalid && en[1];

    always_comb begin
        ramping  = $signed({r_target[31], r_target}) < $signed({2'b00, r_setpoint});
        ramp_sum = $signed({r_target[31], r_target}) + $signed({2'b00, r_ramp_step});
        if (in_start) begin
            n_target = '0;
        end else if (ramping) begin
            n_target = sat33(ramp_sum);
        end else begin
            n_target = $signed({1'b0, r_setpoint});
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_target <= '0;
        end else if (in_acc) begin
            r_target <= n_target;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en[1]) begin
            r_p1_start  <= in_start;
            r_p1_mute   <= i_s_tdata[32];
            r_p1_meas   <= i_s_tdata[31:0];
            r_p1_target <= n_target;
            r_p1_ramp   <= !in_start && ramping;
        end
    end

    // stage 2: raw error
    logic signed [32:0] diff2;

    assign diff2 = $signed({r_p1_target[31], r_p1_target}) - $signed({r_p1_meas[31], r_p1_meas});

    always_ff @(posedge i_clk) begin
        if (en[2]) begin
            r_p2_start  <= r_p1_start;
            r_p2_mute   <= r_p1_mute;
            r_p2_ramp   <= r_p1_ramp;
            r_p2_raw    <= sat33(diff2);
            r_p2_target <= r_p1_target;
        end
    end

    // stage 3: following error, point count, sync line
    logic               upd3, below, fault3, fin3;
    logic signed [31:0] err3;
    logic signed [32:0] err_x, alw_x, alw_neg;
    logic [15:0]        n_follow, n_pc;
    logic [6:0]         n_toggle, tc_inc;
    logic [2:0]         n_sync_cnt;
    logic               n_sync_line;

    assign upd3 = en[3] && r_vld[2];

    always_comb begin
        err3    = (r_pc == 16'd0) ? 32'sd0 : r_p2_raw;
        err_x   = {err3[31], err3};
        alw_x   = $signed({2'b00, r_allowed});
        alw_neg = 33'sd0 - alw_x;
        below   = (err_x < alw_x) && (err_x > alw_neg);

        n_toggle    = r_p2_ramp ? 7'd0 : r_toggle;
        n_sync_cnt  = r_p2_ramp ? 3'd0 : r_sync_cnt;
        n_sync_line = r_sync_line;
        tc_inc      = n_toggle + 7'd1;
        if (r_pc >= 16'(SYNC_START) && n_sync_cnt < 3'(SYNC_TOGGLES)) begin
            if (tc_inc >= 7'(SYNC_PERIOD)) begin
                n_toggle    = 7'd0;
                n_sync_line = !r_sync_line;
                n_sync_cnt  = n_sync_cnt + 3'd1;
            end else begin
                n_toggle = tc_inc;
            end
        end

        if (below) begin
            n_follow = (r_follow != 16'd0) ? r_follow - 16'd1 : r_follow;
        end else begin
            n_follow = (r_follow != 16'hffff) ? r_follow + 16'd1 : r_follow;
        end

        fault3 = !r_p2_mute && (n_follow >= r_fault_limit);
        if (fault3) begin
            n_pc = r_pc;
        end else begin
            n_pc = (r_pc != 16'hffff) ? r_pc + 16'd1 : r_pc;
        end
        fin3 = fault3 || (n_pc >= r_pulse_points);

        if (r_p2_start) begin
            err3        = '0;
            n_follow    = '0;
            n_pc        = '0;
            n_toggle    = r_toggle;
            n_sync_cnt  = r_sync_cnt;
            n_sync_line = r_sync_line;
            fault3      = 1'b0;
            fin3        = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc        <= '0;
            r_follow    <= '0;
            r_toggle    <= '0;
            r_sync_cnt  <= '0;
            r_sync_line <= 1'b0;
        end else if (upd3) begin
            r_pc        <= n_pc;
            r_follow    <= n_follow;
            r_toggle    <= n_toggle;
            r_sync_cnt  <= n_sync_cnt;
            r_sync_line <= n_sync_line;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en[3]) begin
            r_meta[3] <= '{target: r_p2_target, err: err3, fin: fin3, fault: fault3,
                           sync: n_sync_line, start: r_p2_start};
        end
        for (int k = 4; k <= 7; k++) begin
            if (en[k]) begin
                r_meta[k] <= r_meta[k-1];
            end
        end
    end

    // stages 4 to 6: gain products
    t_gm_ctl             gm_ctl;
    logic [GM_MAG_W-1:0] kp_mag, ki_mag;
    logic                kp_neg, ki_neg;

    assign gm_ctl = '{en1: en[4], en2: en[5], en3: en[6]};

    rpvr_gain_mul u_prop (
        .i_clk  (i_clk),
        .i_ctl  (gm_ctl),
        .i_err  (r_meta[3].err),
        .i_gain (r_prop_gain),
        .o_mag  (kp_mag),
        .o_neg  (kp_neg)
    );

    rpvr_gain_mul u_integ (
        .i_clk  (i_clk),
        .i_ctl  (gm_ctl),
        .i_err  (r_meta[3].err),
        .i_gain (r_integral_gain),
        .o_mag  (ki_mag),
        .o_neg  (ki_neg)
    );

    // stage 7: integral with clamp
    logic               upd7;
    logic signed [39:0] i_x, q_x, lim_x, isum;
    logic signed [31:0] n_integral;

    assign upd7 = en[7] && r_vld[6];

    always_comb begin
        i_x   = {{8{r_integral[31]}}, r_integral};
        q_x   = $signed({2'b00, ki_mag});
        lim_x = $signed({9'd0, r_integral_limit});
        isum  = ki_neg ? i_x - q_x : i_x + q_x;
        if (isum > lim_x) begin
            isum = lim_x;
        end else if (isum < -lim_x) begin
            isum = -lim_x;
        end
        n_integral = r_meta[6].start ? 32'sd0 : isum[31:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_integral <= '0;
        end else if (upd7) begin
            r_integral <= n_integral;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en[7]) begin
            r_p7_qi     <= n_integral;
            r_p7_qp_mag <= kp_mag;
            r_p7_qp_neg <= kp_neg;
        end
    end

    // stage 8: drive sum with clamp, result register
    logic signed [40:0] t_x, qi_x, qp_x, dsum;
    logic signed [31:0] n_drive;

    always_comb begin
        t_x  = {{9{r_meta[7].target[31]}}, r_meta[7].target};
        qi_x = {{9{r_p7_qi[31]}}, r_p7_qi};
        qp_x = $signed({3'b000, r_p7_qp_mag});
        dsum = r_p7_qp_neg ? t_x + qi_x - qp_x : t_x + qi_x + qp_x;
        if (dsum > DRV_MAX) begin
            dsum = DRV_MAX;
        end else if (dsum < DRV_MIN) begin
            dsum = DRV_MIN;
        end
        n_drive = r_meta[7].start ? 32'sd0 : dsum[31:0];
    end

    always_ff @(posedge i_clk) begin
        if (en[8]) begin
            r_out_drive <= n_drive;
            r_out_err   <= r_meta[7].err;
            r_out_fin   <= r_meta[7].fin;
            r_out_fault <= r_meta[7].fault;
            r_out_sync  <= r_meta[7].sync;
        end
    end

    assign o_m_tvalid = r_vld[8];
    assign o_m_tdata  = {7'd0, r_out_err, r_out_sync, r_out_drive};
    assign o_m_tuser  = r_out_fault;
    assign o_m_tlast  = r_out_fin;

endmodule

`default_nettype wire

// File: sv/rpvr_gain_mul.sv
// Three-stage gain unit: magnitude of trunc(err * gain / 1000) and its sign.
// Division by 1000 by a split reciprocal multiply. Depends on rpvr_pkg.
`default_nettype none

module rpvr_gain_mul (
    input  wire logic                          i_clk,
    input  wire rpvr_pkg::t_gm_ctl             i_ctl,
    input  wire logic signed [31:0]            i_err,
    input  wire logic        [15:0]            i_gain,
    output logic             [rpvr_pkg::GM_MAG_W-1:0] o_mag,
    output logic                               o_neg
);
    import rpvr_pkg::*;

    // ceil(2^57 / 1000): exact floor(n / 1000) for n < 2^47
    localparam logic [47:0] RECIP = 48'(((64'd1 << 57) + 64'd999) / 64'd1000);

    logic [31:0] err_abs;
    logic [47:0] r_prod;
    logic        r_neg1, r_neg2, r_neg3;
    logic [46:0] r_pp11, r_pp10;
    logic [47:0] r_pp01, r_pp00;
    logic [95:0] n_sum;
    logic [GM_MAG_W-1:0] r_mag;

    assign err_abs = i_err[31] ? (~i_err + 32'd1) : i_err;

    always_comb begin
        n_sum = (96'(r_pp11) << 48) + (96'(r_pp10) << 24) + (96'(r_pp01) << 24)
              + 96'(r_pp00);
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.en1) begin
            r_prod <= err_abs * i_gain;
            r_neg1 <= i_err[31];
        end
        if (i_ctl.en2) begin
            r_pp11 <= r_prod[46:24] * RECIP[47:24];
            r_pp10 <= r_prod[46:24] * RECIP[23:0];
            r_pp01 <= r_prod[23:0] * RECIP[47:24];
            r_pp00 <= r_prod[23:0] * RECIP[23:0];
            r_neg2 <= r_neg1;
        end
        if (i_ctl.en3) begin
            r_mag  <= n_sum[94:57];
            r_neg3 <= r_neg2;
        end
    end

    assign o_mag = r_mag;
    assign o_neg = r_neg3;

endmodule

`default_nettype wire

// File: sv/rpvr_checker.sv
// Port-level checks of the regulator result channel, bound to the core.
// Depends on rpvr_pkg and ramped_pi_voltage_regulator_core.
`default_nettype none

module rpvr_checker (
    input wire logic                               i_clk,
    input wire logic                               i_rst_n,
    input wire logic                               o_m_tvalid,
    input wire logic                               i_m_tready,
    input wire logic [rpvr_pkg::OUT_DATA_W-1:0]    o_m_tdata,
    input wire logic [0:0]                         o_m_tuser,
    input wire logic                               o_m_tlast
);
    import rpvr_pkg::*;

    a_no_result_after_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_tvalid)
        else $error("result valid right after reset");

    a_fault_ends_pulse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && o_m_tuser[0] |-> o_m_tlast)
        else $error("fault without finished");

    a_drive_clamped: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> $signed(o_m_tdata[31:0]) <= OUT_MAX)
        else $error("drive above clamp");

    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata)
                                      && $stable(o_m_tlast) && $stable(o_m_tuser))
        else $error("stalled result changed");

endmodule

bind ramped_pi_voltage_regulator_core rpvr_checker u_rpvr_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata),
    .o_m_tuser  (o_m_tuser),
    .o_m_tlast  (o_m_tlast)
);

`default_nettype wire

// File: test/tb_ramped_pi_voltage_regulator_core.sv
// Testbench for ramped_pi_voltage_regulator_core: directed table, a long sync-burst pulse
// and random pulses; every result is checked against a typed value or a cycle-free predictor.
// Depends on rpvr_pkg and the core RTL.

module tb_ramped_pi_voltage_regulator_core;
    timeunit 1ns;
    timeprecision 1ps;

    import rpvr_pkg::*;

    localparam int     IDLE_PCT      = 30;
    localparam int     STALL_LIMIT   = 2000;
    localparam int     DRAIN_CYCLES  = 16;
    localparam int     RANDOM_ITEMS  = 360;
    localparam int     BURST_SAMPLES = 560;
    localparam int     COUNT_MAX     = 65535;
    localparam longint GAIN_SCALE    = 1000;

    typedef struct packed {
        logic [31:0] drive;
        logic        finished;
        logic        fault;
        logic        sync;
        logic [31:0] err;
    } t_drive_result;

    typedef struct packed {
        logic          is_cfg;
        t_cfg_idx      idx;
        logic [30:0]   value;
        logic          act;
        logic [31:0]   meas;
        logic          mute;
        logic          typed;
        t_drive_result res;
    } t_stim_row;

    logic                  i_clk;
    logic                  i_rst_n    = 1'b0;
    logic [IN_DATA_W-1:0]  i_s_tdata  = '0;
    logic [0:0]            i_s_tuser  = '0;
    logic                  i_s_tvalid = 1'b0;
    logic                  o_s_tready;
    logic [OUT_DATA_W-1:0] o_m_tdata;
    logic [0:0]            o_m_tuser;
    logic                  o_m_tlast;
    logic                  o_m_tvalid;
    logic                  i_m_tready = 1'b0;
    logic                  i_cfg_we   = 1'b0;
    t_cfg_idx              i_cfg_idx  = CFG_SETPOINT;
    logic [CFG_W-1:0]      i_cfg_data = '0;

    ramped_pi_voltage_regulator_core i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser),
        .o_m_tlast  (o_m_tlast),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    // predictor state and register copy
    longint cfg_reg [8];
    int     tgt_v;
    int     integ_v;
    int     pcount;
    int     fcount;
    int     tcount;
    int     scount;
    bit     sline;

    t_drive_result expected_drives [$];
    t_stim_row     directed_rows [$];
    int            fail_count;
    int            results_seen;
    bit            calm;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic longint clip32(input longint v);
        if (v > 64'sd2147483647) return 64'sd2147483647;
        if (v < -64'sd2147483648) return -64'sd2147483648;
        return v;
    endfunction

    function automatic t_drive_result regulate(input logic act, input logic [31:0] meas_bits,
                                               input logic mute);
        t_drive_result r;
        longint meas, err, mag, p_term, i_term, drive, lim;
        r = '0;
        if (act) begin
            tgt_v   = 0;
            integ_v = 0;
            pcount  = 0;
            fcount  = 0;
            r.sync  = sline;
            return r;
        end
        meas = longint'($signed(meas_bits));
        if (longint'(tgt_v) < cfg_reg[CFG_SETPOINT]) begin
            scount = 0;
            tcount = 0;
            tgt_v  = int'(clip32(longint'(tgt_v) + cfg_reg[CFG_RAMP_STEP]));
        end else begin
            tgt_v = int'(cfg_reg[CFG_SETPOINT]);
        end
        if (pcount >= SYNC_START && scount < SYNC_TOGGLES) begin
            tcount = (tcount + 1) & 32'h7F;
            if (tcount >= SYNC_PERIOD) begin
                tcount = 0;
                sline  = ~sline;
                scount = (scount + 1) & 32'h7;
            end
        end
        err = (pcount == 0) ? 0 : clip32(longint'(tgt_v) - meas);
        mag = (err < 0) ? -err : err;
        if (mag < cfg_reg[CFG_ALLOWED_ERROR]) begin
            if (fcount != 0) fcount--;
        end else if (fcount < COUNT_MAX) begin
            fcount++;
        end
        lim    = cfg_reg[CFG_INTEGRAL_LIMIT];
        i_term = longint'(integ_v) + err * cfg_reg[CFG_INTEGRAL_GAIN] / GAIN_SCALE;
        if (i_term > lim) i_term = lim;
        if (i_term < -lim) i_term = -lim;
        integ_v = int'(i_term);
        p_term  = err * cfg_reg[CFG_PROP_GAIN] / GAIN_SCALE;
        drive   = longint'(tgt_v) + p_term + i_term;
        if (drive > OUT_MAX) drive = OUT_MAX;
        drive = clip32(drive);
        if (!mute && fcount >= cfg_reg[CFG_FAULT_LIMIT]) begin
            r.fault    = 1'b1;
            r.finished = 1'b1;
        end else begin
            if (pcount < COUNT_MAX) pcount++;
            r.finished = (pcount >= cfg_reg[CFG_PULSE_POINTS]);
        end
        r.drive = drive[31:0];
        r.sync  = sline;
        r.err   = err[31:0];
        return r;
    endfunction

    function automatic t_drive_result outcome(input logic [31:0] drive, input logic finished,
                                              input logic fault, input logic sync,
                                              input logic [31:0] err);
        return {drive, finished, fault, sync, err};
    endfunction

    function automatic t_stim_row reg_row(input t_cfg_idx idx, input logic [30:0] value);
        t_stim_row row;
        row        = '0;
        row.is_cfg = 1'b1;
        row.idx    = idx;
        row.value  = value;
        return row;
    endfunction

    function automatic t_stim_row sample_row(input logic act, input logic [31:0] meas,
                                             input logic mute);
        t_stim_row row;
        row      = '0;
        row.act  = act;
        row.meas = meas;
        row.mute = mute;
        return row;
    endfunction

    function automatic t_stim_row checked_row(input logic act, input logic [31:0] meas,
                                              input logic mute, input t_drive_result res);
        t_stim_row row;
        row       = sample_row(act, meas, mute);
        row.typed = 1'b1;
        row.res   = res;
        return row;
    endfunction

    function automatic logic [30:0] wide_pick(input logic [30:0] typical, input int bits);
        logic [30:0] full_mask;
        full_mask = (31'h7FFF_FFFF >> (31 - bits));
        case ($urandom_range(7))
            0:       return '0;
            1:       return full_mask;
            2:       return 31'($urandom) & full_mask;
            default: return typical;
        endcase
    endfunction

    function automatic logic [31:0] pick_measurement();
        int unsigned span;
        span = 1 << $urandom_range(4, 20);
        case ($urandom_range(9))
            0:       return $urandom;
            1:       return $urandom_range(1) ? 32'h7FFF_FFFF : 32'h8000_0000;
            default: return tgt_v + $urandom_range(0, 2 * span) - span;
        endcase
    endfunction

    task automatic note_failure(input string msg);
        fail_count++;
        if (fail_count <= 10) $display("%s", msg);
    endtask

    task automatic send_sample(input t_stim_row row);
        t_drive_result predicted;
        while (!calm && $urandom_range(99) < IDLE_PCT) begin
            i_s_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= {7'b0, row.mute, row.meas};
        i_s_tuser  <= row.act;
        do @(posedge i_clk); while (!o_s_tready);
        predicted = regulate(row.act, row.meas, row.mute);
        expected_drives.push_back(row.typed ? row.res : predicted);
    endtask

    // registers change only with the pipeline drained
    task automatic write_reg(input t_cfg_idx idx, input logic [30:0] value);
        i_s_tvalid <= 1'b0;
        while (expected_drives.size() != 0) @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= value;
        @(posedge i_clk);
        i_cfg_we     <= 1'b0;
        cfg_reg[idx] = value;
        @(posedge i_clk);
    endtask

    task automatic load_random_config();
        logic [30:0] vals [8];
        logic [30:0] sp;
        sp                      = wide_pick(31'($urandom_range(0, 50 << 16)), 31);
        vals[CFG_SETPOINT]      = sp;
        vals[CFG_RAMP_STEP]     = wide_pick(31'(sp / $urandom_range(1, 60)), 31);
        vals[CFG_PULSE_POINTS]  = wide_pick(31'($urandom_range(1, 800)), 16);
        vals[CFG_PROP_GAIN]     = wide_pick(31'($urandom_range(0, 3000)), 16);
        vals[CFG_INTEGRAL_GAIN] = wide_pick(31'($urandom_range(0, 3000)), 16);
        vals[CFG_ALLOWED_ERROR] = wide_pick(31'($urandom_range(0, 4 << 16)), 31);
        vals[CFG_FAULT_LIMIT]   = wide_pick(31'($urandom_range(0, 40)), 16);
        vals[CFG_INTEGRAL_LIMIT] = wide_pick(31'($urandom_range(0, 20 << 16)), 31);
        for (int i = 0; i < 8; i++) write_reg(t_cfg_idx'(i), vals[i]);
    endtask

    always @(posedge i_clk) begin : result_check
        t_drive_result want, got;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            got = {o_m_tdata[31:0], o_m_tlast, o_m_tuser[0], o_m_tdata[32], o_m_tdata[64:33]};
            if (expected_drives.size() == 0) begin
                note_failure($sformatf("result %0d: unexpected transfer, drive %h error %h",
                                       results_seen, got.drive, got.err));
            end else begin
                want = expected_drives.pop_front();
                if (got !== want)
                    note_failure($sformatf(
                        "result %0d: drive %h/%h fin %b/%b fault %b/%b sync %b/%b err %h/%h",
                        results_seen, want.drive, got.drive, want.finished, got.finished,
                        want.fault, got.fault, want.sync, got.sync, want.err, got.err));
            end
            results_seen++;
        end
        i_m_tready <= calm || ($urandom_range(99) >= IDLE_PCT);
    end

    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT) begin
            @(posedge i_clk);
            if ((i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready)) quiet = 0;
            else quiet++;
        end
        $display("ramped_pi_voltage_regulator_core test failed");
        $finish;
    end

    initial begin : stimulus
        int random_items;
        int pulse_len;
        random_items = 0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        directed_rows = '{
            // reset registers: zero fault limit faults at once, then mute and extremes
            checked_row(1'b0, 32'h0000_0000, 1'b0, outcome(32'h0, 1'b1, 1'b1, 1'b0, 32'h0)),
            checked_row(1'b1, 32'hFFFF_FFFF, 1'b1, outcome(32'h0, 1'b0, 1'b0, 1'b0, 32'h0)),
            checked_row(1'b0, 32'h8000_0000, 1'b1, outcome(32'h0, 1'b1, 1'b0, 1'b0, 32'h0)),
            checked_row(1'b0, 32'h8000_0000, 1'b1,
                        outcome(32'h0, 1'b1, 1'b0, 1'b0, 32'h7FFF_FFFF)),
            checked_row(1'b0, 32'h7FFF_FFFF, 1'b1,
                        outcome(32'h0, 1'b1, 1'b0, 1'b0, 32'h8000_0001)),
            sample_row(1'b0, 32'h0000_0001, 1'b0),
            // full-scale registers: ramp saturates, drive clamps at the top
            reg_row(CFG_SETPOINT, 31'h7FFF_FFFF),
            reg_row(CFG_RAMP_STEP, 31'h4000_0000),
            reg_row(CFG_PULSE_POINTS, 31'd4),
            reg_row(CFG_PROP_GAIN, 31'hFFFF),
            reg_row(CFG_INTEGRAL_GAIN, 31'hFFFF),
            reg_row(CFG_ALLOWED_ERROR, 31'h7FFF_FFFF),
            reg_row(CFG_FAULT_LIMIT, 31'hFFFF),
            reg_row(CFG_INTEGRAL_LIMIT, 31'h7FFF_FFFF),
            sample_row(1'b1, 32'h0000_0000, 1'b0),
            sample_row(1'b0, 32'h0000_0000, 1'b0),
            sample_row(1'b0, 32'h8000_0000, 1'b0),
            sample_row(1'b0, 32'h7FFF_FFFF, 1'b0),
            sample_row(1'b0, 32'h7FFF_FFFF, 1'b1),
            sample_row(1'b0, 32'h7FFF_FFFF, 1'b0),
            // small ramp that overshoots, drive clamps at the bottom, fault at limit 2
            reg_row(CFG_SETPOINT, 31'd1000),
            reg_row(CFG_RAMP_STEP, 31'd300),
            reg_row(CFG_PULSE_POINTS, 31'hFFFF),
            reg_row(CFG_PROP_GAIN, 31'hFFFF),
            reg_row(CFG_INTEGRAL_GAIN, 31'd999),
            reg_row(CFG_ALLOWED_ERROR, 31'd0),
            reg_row(CFG_FAULT_LIMIT, 31'd2),
            reg_row(CFG_INTEGRAL_LIMIT, 31'd5000),
            sample_row(1'b1, 32'h1234_5678, 1'b1),
            sample_row(1'b0, 32'h7FFF_FFFF, 1'b0),
            sample_row(1'b0, 32'h7FFF_FFFF, 1'b0),
            sample_row(1'b0, 32'd1200, 1'b1),
            sample_row(1'b0, 32'd1000, 1'b1),
            sample_row(1'b0, 32'h0000_0000, 1'b0)
        };
        foreach (directed_rows[i]) begin
            if (directed_rows[i].is_cfg) write_reg(directed_rows[i].idx, directed_rows[i].value);
            else send_sample(directed_rows[i]);
        end

        // one long pulse without idling: ramp, then the whole sync burst
        calm = 1'b1;
        write_reg(CFG_SETPOINT, 31'h0001_0000);
        write_reg(CFG_RAMP_STEP, 31'h0000_1000);
        write_reg(CFG_PULSE_POINTS, 31'hFFFF);
        write_reg(CFG_PROP_GAIN, 31'd500);
        write_reg(CFG_INTEGRAL_GAIN, 31'd20);
        write_reg(CFG_ALLOWED_ERROR, 31'd0);
        write_reg(CFG_FAULT_LIMIT, 31'hFFFF);
        write_reg(CFG_INTEGRAL_LIMIT, 31'h0010_0000);
        send_sample(sample_row(1'b1, $urandom, 1'b0));
        for (int k = 0; k < BURST_SAMPLES; k++)
            send_sample(sample_row(1'b0, pick_measurement(), 1'b1));
        repeat (4) send_sample(sample_row(1'b0, pick_measurement(), 1'b0));
        calm = 1'b0;

        while (random_items < RANDOM_ITEMS) begin
            load_random_config();
            pulse_len = ($urandom_range(3) == 0) ? $urandom_range(200, 300)
                                                 : $urandom_range(20, 120);
            if ($urandom_range(7) != 0) begin
                send_sample(sample_row(1'b1, $urandom, 1'($urandom_range(1))));
                random_items++;
            end
            for (int k = 0; k < pulse_len && random_items < RANDOM_ITEMS; k++) begin
                send_sample(sample_row($urandom_range(199) == 0, pick_measurement(),
                                       $urandom_range(3) == 0));
                random_items++;
            end
        end
        i_s_tvalid <= 1'b0;

        while (expected_drives.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fail_count == 0 && expected_drives.size() == 0) begin
            $display("ramped_pi_voltage_regulator_core test passed");
        end else begin
            $display("ramped_pi_voltage_regulator_core test failed");
        end
        $finish;
    end

endmodule
